// ===== hdl/bytea_unescape_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// bytea unescape decoder assertion macros
// concurrent assertion shorthands shared by the checker
// ----------------------------------------------------------------------------
`ifndef BYTEA_UNESCAPE_DECODER_MACROS_SVH
`define BYTEA_UNESCAPE_DECODER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BUD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define BUD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bud_pkg.sv =====
// ----------------------------------------------------------------------------
// bud_pkg
// types and character constants shared by the escaped-text decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bud_pkg;

  // character codes
  localparam logic [7:0] BACKSLASH  = 8'h5C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_THREE = 8'h33;
  localparam logic [7:0] CHAR_SEVEN = 8'h37;

  // results one item can cause, and result queue depth
  localparam int MAX_RES     = 3;
  localparam int QUEUE_DEPTH = 4;

  // escape tracking state
  typedef enum logic [3:0] {
    PH_PLAIN = 4'b0001,
    PH_ESC   = 4'b0010,
    PH_D1    = 4'b0100,
    PH_D2    = 4'b1000
  } phase_t;

  // one result item
  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       bad;
    logic       eot;
    logic       lor;
  } res_t;

  // decoder state
  typedef struct packed {
    phase_t     phase;
    logic [1:0] d1;
    logic [2:0] d2;
  } st_t;

  // decoder outcome for one item
  typedef struct packed {
    logic [1:0]         cnt;
    res_t [MAX_RES-1:0] ent;
    st_t                nxt;
  } dec_t;

endpackage

// ===== hdl/bud_decode.sv =====
// ----------------------------------------------------------------------------
// bud_decode
// decodes one character against the escape state into up to three results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bud_decode (
  input  logic [7:0]    ch,
  input  logic          last,
  input  bud_pkg::st_t  st,
  output bud_pkg::dec_t dec
);

  logic                        is_bs;
  logic                        is_oct;
  logic                        is_first;
  bud_pkg::phase_t             ph;
  logic [1:0]                  n;
  logic                        bad;
  logic [1:0]                  d1n;
  logic [2:0]                  d2n;
  bud_pkg::res_t [bud_pkg::MAX_RES-1:0] ent;

  function automatic bud_pkg::res_t mk(input logic [7:0] b, input logic v);
    bud_pkg::res_t r;
    r            = '0;
    r.data       = b;
    r.byte_valid = v;
    return r;
  endfunction

  // character classes
  assign is_bs    = (ch == bud_pkg::BACKSLASH);
  assign is_oct   = ch inside {[bud_pkg::CHAR_ZERO:bud_pkg::CHAR_SEVEN]};
  assign is_first = ch inside {[bud_pkg::CHAR_ZERO:bud_pkg::CHAR_THREE]};

  // result list and next state
  always_comb begin
    ph  = st.phase;
    n   = 2'd0;
    bad = 1'b0;
    d1n = st.d1;
    d2n = st.d2;
    ent = '0;

    case (st.phase)
      bud_pkg::PH_PLAIN: begin
        if (is_bs) begin
          ph = bud_pkg::PH_ESC;
        end else begin
          ent[n] = mk(ch, 1'b1);
          n      = n + 2'd1;
        end
      end
      bud_pkg::PH_ESC: begin
        if (is_bs) begin
          ent[n] = mk(bud_pkg::BACKSLASH, 1'b1);
          n      = n + 2'd1;
          ph     = bud_pkg::PH_PLAIN;
        end else if (is_first) begin
          d1n = ch[1:0];
          ph  = bud_pkg::PH_D1;
        end else begin
          bad    = 1'b1;
          ent[n] = mk(ch, 1'b1);
          n      = n + 2'd1;
          ph     = bud_pkg::PH_PLAIN;
        end
      end
      bud_pkg::PH_D1: begin
        if (is_oct) begin
          d2n = ch[2:0];
          ph  = bud_pkg::PH_D2;
        end else begin
          bad    = 1'b1;
          ent[n] = mk(bud_pkg::CHAR_ZERO + {6'd0, st.d1}, 1'b1);
          n      = n + 2'd1;
          if (is_bs) begin
            ph = bud_pkg::PH_ESC;
          end else begin
            ent[n] = mk(ch, 1'b1);
            n      = n + 2'd1;
            ph     = bud_pkg::PH_PLAIN;
          end
        end
      end
      bud_pkg::PH_D2: begin
        if (is_oct) begin
          ent[n] = mk({st.d1, st.d2, ch[2:0]}, 1'b1);
          n      = n + 2'd1;
          ph     = bud_pkg::PH_PLAIN;
        end else begin
          bad    = 1'b1;
          ent[n] = mk(bud_pkg::CHAR_ZERO + {6'd0, st.d1}, 1'b1);
          n      = n + 2'd1;
          ent[n] = mk(bud_pkg::CHAR_ZERO + {5'd0, st.d2}, 1'b1);
          n      = n + 2'd1;
          if (is_bs) begin
            ph = bud_pkg::PH_ESC;
          end else begin
            ent[n] = mk(ch, 1'b1);
            n      = n + 2'd1;
            ph     = bud_pkg::PH_PLAIN;
          end
        end
      end
      default: begin
        ph = bud_pkg::PH_PLAIN;
      end
    endcase

    // end of text: flush held digits, drop a lone backslash
    if (last) begin
      if (ph != bud_pkg::PH_PLAIN) begin
        bad = 1'b1;
      end
      if (ph == bud_pkg::PH_D1 || ph == bud_pkg::PH_D2) begin
        ent[n] = mk(bud_pkg::CHAR_ZERO + {6'd0, d1n}, 1'b1);
        n      = n + 2'd1;
      end
      if (ph == bud_pkg::PH_D2) begin
        ent[n] = mk(bud_pkg::CHAR_ZERO + {5'd0, d2n}, 1'b1);
        n      = n + 2'd1;
      end
      ph = bud_pkg::PH_PLAIN;
      if (n == 2'd0) begin
        ent[n] = mk(8'h00, 1'b0);
        n      = n + 2'd1;
      end
      ent[n - 2'd1].eot = 1'b1;
    end

    // flags: bad-escape for the whole run, last-of-run on its final result
    for (int k = 0; k < bud_pkg::MAX_RES; k++) begin
      ent[k].bad = bad;
    end
    if (n != 2'd0) begin
      ent[n - 2'd1].lor = 1'b1;
    end
  end

  assign dec.cnt       = n;
  assign dec.ent       = ent;
  assign dec.nxt.phase = ph;
  assign dec.nxt.d1    = d1n;
  assign dec.nxt.d2    = d2n;

endmodule

// ===== hdl/bytea_unescape_decoder.sv =====
// ----------------------------------------------------------------------------
// bytea_unescape_decoder
// turns backslash-escaped text into raw bytes, one character per item
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one character (in_char) and a flag
// marking the final character of a text (in_last_char). Output channel
// out_valid/out_ready carries one decoded byte per item with its flags:
// byte_valid (low only on a bare end marker), bad_escape, end_of_text and
// last_of_run (last result caused by one input item).
// One character causes zero to three results. An accepted character is
// registered in the input stage and decoded combinationally; when that stage
// advances, its results are written into a four-entry result queue, whose
// head is offered on the output channel.
// Throughput: one character per cycle while results average one per input;
// a character that yields two or three results lets the queue absorb the
// burst, and the input stage holds while the queue has more than one entry.
// When the receiver stalls the queue fills and in_ready drops; nothing is
// lost. Synchronous active-low reset empties the pipeline and queue and
// returns the decoder to plain-text state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bytea_unescape_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_bad_escape,
  output logic       out_end_of_text,
  output logic       out_last_of_run
);

  logic                                    a_valid_r;
  logic [7:0]                              a_char_r;
  logic                                    a_last_r;
  logic                                    a_fire;
  bud_pkg::st_t                            st_r;
  bud_pkg::dec_t                           dec;
  bud_pkg::res_t [bud_pkg::QUEUE_DEPTH-1:0] q_r;
  bud_pkg::res_t [bud_pkg::QUEUE_DEPTH-1:0] q_nxt;
  logic [2:0]                              q_cnt_r;
  logic [2:0]                              q_cnt_nxt;
  logic [2:0]                              base;
  logic [2:0]                              idx;
  logic                                    pop;

  // input stage advances when the queue can take a full run
  assign a_fire   = a_valid_r && (q_cnt_r <= 3'd1);
  assign in_ready = !a_valid_r || a_fire;
  assign pop      = out_valid && out_ready;

  // character decode
  bud_decode u_dec (
    .ch   (a_char_r),
    .last (a_last_r),
    .st   (st_r),
    .dec  (dec)
  );

  // result queue: shift out at the head, append the new run behind
  always_comb begin
    base = q_cnt_r - {2'd0, pop};
    idx  = base;
    for (int i = 0; i < bud_pkg::QUEUE_DEPTH; i++) begin
      if (pop && i < bud_pkg::QUEUE_DEPTH - 1) begin
        q_nxt[i] = q_r[i + 1];
      end else begin
        q_nxt[i] = q_r[i];
      end
    end
    for (int k = 0; k < bud_pkg::MAX_RES; k++) begin
      idx = base + 3'(k);
      if (a_fire && 2'(k) < dec.cnt) begin
        q_nxt[idx[1:0]] = dec.ent[k];
      end
    end
    q_cnt_nxt = base + (a_fire ? {1'b0, dec.cnt} : 3'd0);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      q_cnt_r   <= 3'd0;
      st_r      <= '{phase: bud_pkg::PH_PLAIN, d1: 2'd0, d2: 3'd0};
    end else begin
      if (in_ready) begin
        a_valid_r <= in_valid;
      end
      q_cnt_r <= q_cnt_nxt;
      if (a_fire) begin
        st_r <= dec.nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_char_r <= in_char;
      a_last_r <= in_last_char;
    end
    q_r <= q_nxt;
  end

  // head of queue drives the output
  assign out_valid       = (q_cnt_r != 3'd0);
  assign out_byte        = q_r[0].data;
  assign out_byte_valid  = q_r[0].byte_valid;
  assign out_bad_escape  = q_r[0].bad;
  assign out_end_of_text = q_r[0].eot;
  assign out_last_of_run = q_r[0].lor;

endmodule

// ===== hdl/bud_checker.sv =====
// ----------------------------------------------------------------------------
// bud_checker
// port-level checks on the escaped-text decoder, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bytea_unescape_decoder_macros.svh"

module bud_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_byte_valid,
  input logic       out_bad_escape,
  input logic       out_end_of_text,
  input logic       out_last_of_run
);

  // a stalled result stays offered
  `BUD_ASSERT_NEXT(a_out_hold, clk, rst_n,
    out_valid && !out_ready, out_valid && $stable(out_byte),
    "result dropped under stall")

  // a bare end marker is zero and closes both the run and the text
  `BUD_ASSERT_NOW(a_bare_marker, clk, rst_n,
    out_valid && !out_byte_valid,
    out_byte == 8'h00 && out_end_of_text && out_last_of_run,
    "malformed end marker")

  // end of text always closes the run
  `BUD_ASSERT_NOW(a_eot_closes, clk, rst_n,
    out_valid && out_end_of_text, out_last_of_run,
    "end of text inside a run")

  // the rest of a run follows at once, with the same bad-escape flag
  `BUD_ASSERT_NEXT(a_run_cont, clk, rst_n,
    out_valid && out_ready && !out_last_of_run,
    out_valid && out_bad_escape == $past(out_bad_escape),
    "run broken")

  // an empty result side never blocks the input
  `BUD_ASSERT_NOW(a_empty_ready, clk, rst_n,
    !out_valid, in_ready,
    "input blocked with empty queue")

endmodule

bind bytea_unescape_decoder bud_checker u_bud_checker (.*);

// ===== tb/bud_stream_checker.sv =====
// ----------------------------------------------------------------------------
// bud_stream_checker
// watches both channels of the escaped-text decoder, predicts the decoded
// bytes of every accepted character and compares each result item in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bud_stream_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_last_char,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_byte_valid,
  input  logic       out_bad_escape,
  input  logic       out_end_of_text,
  input  logic       out_last_of_run,
  output int         fail_count,
  output int         pending,
  output int         chars_seen,
  output int         results_seen
);

  // decoded bytes still owed by the block, oldest first
  bud_pkg::res_t   due_bytes[$];

  // predicted escape state
  bud_pkg::phase_t esc_phase;
  logic [1:0] dig_hi;
  logic [2:0] dig_mid;

  // results of the character being decoded
  bud_pkg::res_t   run_res [0:bud_pkg::MAX_RES-1];
  int     run_cnt;

  initial begin
    fail_count   = 0;
    pending      = 0;
    chars_seen   = 0;
    results_seen = 0;
    esc_phase    = bud_pkg::PH_PLAIN;
    dig_hi       = '0;
    dig_mid      = '0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic string fmt_res(input bud_pkg::res_t r);
    return $sformatf("byte %02h valid %0b bad %0b eot %0b last %0b",
                     r.data, r.byte_valid, r.bad, r.eot, r.lor);
  endfunction

  function automatic void emit(input logic [7:0] b, input logic v);
    bud_pkg::res_t r;
    r = '0;
    r.data = b;
    r.byte_valid = v;
    run_res[run_cnt] = r;
    run_cnt++;
  endfunction

  // a character seen in plain state: backslash opens an escape
  function automatic void take_plain(input logic [7:0] c);
    if (c == bud_pkg::BACKSLASH) begin
      esc_phase = bud_pkg::PH_ESC;
    end else begin
      emit(c, 1'b1);
      esc_phase = bud_pkg::PH_PLAIN;
    end
  endfunction

  // held octal digits go out as their characters
  function automatic void flush_digits();
    if (esc_phase == bud_pkg::PH_D1 || esc_phase == bud_pkg::PH_D2)
      emit(8'(bud_pkg::CHAR_ZERO + dig_hi), 1'b1);
    if (esc_phase == bud_pkg::PH_D2)
      emit(8'(bud_pkg::CHAR_ZERO + dig_mid), 1'b1);
    esc_phase = bud_pkg::PH_PLAIN;
  endfunction

  // decode one character and queue the bytes it should produce
  function automatic void decode_char(input logic [7:0] c, input logic last);
    logic is_oct;
    logic dropped;
    is_oct  = (c >= bud_pkg::CHAR_ZERO) && (c <= bud_pkg::CHAR_SEVEN);
    dropped = 1'b0;
    run_cnt = 0;
    case (esc_phase)
      bud_pkg::PH_PLAIN: take_plain(c);
      bud_pkg::PH_ESC: begin
        if (c == bud_pkg::BACKSLASH) begin
          emit(bud_pkg::BACKSLASH, 1'b1);
          esc_phase = bud_pkg::PH_PLAIN;
        end else if (c >= bud_pkg::CHAR_ZERO && c <= bud_pkg::CHAR_THREE) begin
          dig_hi    = c[1:0];
          esc_phase = bud_pkg::PH_D1;
        end else begin
          dropped   = 1'b1;
          esc_phase = bud_pkg::PH_PLAIN;
          take_plain(c);
        end
      end
      bud_pkg::PH_D1: begin
        if (is_oct) begin
          dig_mid   = c[2:0];
          esc_phase = bud_pkg::PH_D2;
        end else begin
          dropped = 1'b1;
          flush_digits();
          take_plain(c);
        end
      end
      default: begin
        if (is_oct) begin
          emit({dig_hi, dig_mid, c[2:0]}, 1'b1);
          esc_phase = bud_pkg::PH_PLAIN;
        end else begin
          dropped = 1'b1;
          flush_digits();
          take_plain(c);
        end
      end
    endcase

    // end of text closes any open escape
    if (last) begin
      if (esc_phase != bud_pkg::PH_PLAIN) begin
        dropped = 1'b1;
        flush_digits();
      end
      esc_phase = bud_pkg::PH_PLAIN;
      if (run_cnt == 0)
        emit(8'h00, 1'b0);
      run_res[run_cnt-1].eot = 1'b1;
    end

    if (run_cnt > 0)
      run_res[run_cnt-1].lor = 1'b1;
    for (int k = 0; k < run_cnt; k++) begin
      run_res[k].bad = dropped;
      due_bytes.push_back(run_res[k]);
    end
  endfunction

  // compare each accepted result with the oldest expected byte
  task automatic check_result();
    bud_pkg::res_t got;
    bud_pkg::res_t want;
    got.data       = out_byte;
    got.byte_valid = out_byte_valid;
    got.bad        = out_bad_escape;
    got.eot        = out_end_of_text;
    got.lor        = out_last_of_run;
    if (due_bytes.size() == 0) begin
      report_mismatch($sformatf("unexpected result %s", fmt_res(got)));
    end else begin
      want = due_bytes.pop_front();
      if (got !== want)
        report_mismatch($sformatf("got %s, expected %s", fmt_res(got), fmt_res(want)));
    end
    results_seen++;
  endtask

  // sample both channels at the clock edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        check_result();
      if (in_valid && in_ready) begin
        decode_char(in_char, in_last_char);
        chars_seen++;
      end
      pending = due_bytes.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the escaped-text decoder: directed escapes, then
// random texts under changing idle and stall rates and one long output stall
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 80;
  localparam int PHASE_CHARS  = 36;
  localparam int DRAIN_CYCLES = 20;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_ready;
  logic [7:0] in_char      = 8'h00;
  logic       in_last_char = 1'b0;
  logic       out_valid;
  logic       out_ready    = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_bad_escape;
  logic       out_end_of_text;
  logic       out_last_of_run;

  int fail_count;
  int pending;
  int chars_seen;
  int results_seen;

  int   cycles      = 0;
  int   chars_sent  = 0;
  int   texts_sent  = 0;
  int   idle_pct    = 0;
  int   stall_pct   = 0;
  logic hold_off    = 1'b0;

  always #1 clk = ~clk;

  bytea_unescape_decoder u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char         (in_char),
    .in_last_char    (in_last_char),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_bad_escape  (out_bad_escape),
    .out_end_of_text (out_end_of_text),
    .out_last_of_run (out_last_of_run)
  );

  bud_stream_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char         (in_char),
    .in_last_char    (in_last_char),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_bad_escape  (out_bad_escape),
    .out_end_of_text (out_end_of_text),
    .out_last_of_run (out_last_of_run),
    .fail_count      (fail_count),
    .pending         (pending),
    .chars_seen      (chars_seen),
    .results_seen    (results_seen)
  );

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls, or a full hold-off while pressure is on
  always @(posedge clk) begin
    if (!rst_n || hold_off)
      out_ready <= 1'b0;
    else
      out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // offer one character and wait until it is taken
  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char      <= c;
    in_last_char <= last;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_str(input string s, input bit ends_text);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], ends_text && (i == s.len() - 1));
    if (ends_text)
      texts_sent++;
  endtask

  // one token of escaped text: mostly well formed, some broken or cut short
  task automatic send_token(input bit ends_text);
    logic [7:0] tok[$];
    int pick;
    int ndig;
    pick = $urandom_range(99);
    if (pick < 40) begin
      tok.push_back(8'($urandom_range(255)));
    end else if (pick < 55) begin
      tok.push_back(bud_pkg::BACKSLASH);
      tok.push_back(bud_pkg::BACKSLASH);
    end else if (pick < 80) begin
      tok.push_back(bud_pkg::BACKSLASH);
      tok.push_back(8'(bud_pkg::CHAR_ZERO + $urandom_range(3)));
      tok.push_back(8'(bud_pkg::CHAR_ZERO + $urandom_range(7)));
      tok.push_back(8'(bud_pkg::CHAR_ZERO + $urandom_range(7)));
    end else begin
      tok.push_back(bud_pkg::BACKSLASH);
      ndig = $urandom_range(2);
      if (ndig > 0)
        tok.push_back(8'(bud_pkg::CHAR_ZERO + $urandom_range(3)));
      if (ndig > 1)
        tok.push_back(8'(bud_pkg::CHAR_ZERO + $urandom_range(7)));
      // a text may end right inside the escape
      if (!(ends_text && $urandom_range(1) == 1))
        tok.push_back(8'($urandom_range(255)));
    end
    foreach (tok[i])
      send_char(tok[i], ends_text && (i == tok.size() - 1));
  endtask

  task automatic send_text();
    int ntok;
    ntok = $urandom_range(6, 1);
    for (int k = 0; k < ntok; k++)
      send_token(k == ntok - 1);
    texts_sent++;
  endtask

  initial begin
    int goal;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: byte extremes, escaped backslash, octal extremes,
    // escapes broken in each phase, and texts ending inside an escape
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_str("\\\\", 1'b0);
    send_str("\\377", 1'b0);
    send_str("\\000", 1'b0);
    send_str("\\1x", 1'b0);
    send_str("\\12\\4", 1'b0);
    send_str("\\37", 1'b1);
    send_str("\\", 1'b1);
    send_str("A", 1'b1);

    // random texts under four idle and stall mixes
    goal = chars_sent;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 49 : 6) : 0;
      stall_pct <= (ph == 2) ? 49 : ((ph == 3) ? 6 : 0);
      goal += PHASE_CHARS;
      while (chars_sent < goal)
        send_text();
    end

    // long output stall while characters keep coming
    idle_pct  = 0;
    stall_pct <= 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    goal = chars_sent + 20;
    while (chars_sent < goal)
      send_text();

    in_valid     <= 1'b0;
    in_last_char <= 1'b0;

    // drain
    while (pending != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("decoded %0d characters in %0d texts into %0d checked results",
             chars_seen, texts_sent, results_seen);
    if (pending != 0)
      $display("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== bytea_unescape_decoder.f =====
+incdir+hdl
hdl/bud_pkg.sv
hdl/bud_decode.sv
hdl/bytea_unescape_decoder.sv
hdl/bud_checker.sv
tb/bud_stream_checker.sv
tb/tb_top.sv
